// ===== rtl/crtc_pkg.sv =====
`default_nettype none

package crtc_pkg;

    localparam logic OP_INDEX_WRITE = 1'b0;
    localparam logic OP_DATA_READ   = 1'b1;

    localparam logic [6:0] REG_SECOND   = 7'h00;
    localparam logic [6:0] REG_MINUTE   = 7'h02;
    localparam logic [6:0] REG_HOUR     = 7'h04;
    localparam logic [6:0] REG_DAY      = 7'h07;
    localparam logic [6:0] REG_MONTH    = 7'h08;
    localparam logic [6:0] REG_YEAR     = 7'h09;
    localparam logic [6:0] REG_CENTURY  = 7'h32;
    localparam logic [6:0] REG_STATUS_A = 7'h0A;
    localparam logic [6:0] REG_STATUS_B = 7'h0B;

    localparam logic [7:0] STATUS_A_VALUE = 8'h26;
    localparam logic [7:0] STATUS_B_VALUE = 8'h06;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [5:0]  MINS_PER_HOUR = 6'd60;

    // ceil(2^35 / 675): exact quotient of (t >> 7) / 675 for every 32-bit t
    localparam logic [25:0] RECIP_DAY = 26'd50903317;
    // ceil(2^23 / 60): exact quotient of x / 60 for every x below 86400
    localparam logic [17:0] RECIP_MIN = 18'd139811;

    localparam logic [6:0] EPOCH_YY      = 7'd70;
    localparam logic [4:0] EPOCH_CENTURY = 5'd19;
    localparam logic [6:0] LAST_YY       = 7'd99;

    localparam logic [8:0] DAYS_LEAP_YEAR   = 9'd366;
    localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;

    typedef struct packed {
        logic accept;
        logic div_day;
        logic load_min;
        logic div_min;
        logic load_hour;
        logic div_hour;
        logic load_hms;
        logic year_step;
        logic month_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } status_t;

    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cmos_rtc_view_from_epoch_top.sv =====
// CMOS real-time-clock register view over a seconds-since-1970 counter.
// Input channel (s_): s_op selects an index-port write (s_index_value,
// low 7 bits kept) or a data-port read converted from s_epoch_seconds.
// Result channel (m_): one m_read_data byte per input transfer; 0 for an
// index write, otherwise the register picked by the stored index.
// One item is in work at a time. An index write goes straight to the
// finishing state. A data read runs the day, minute and hour splits in
// six steps (three reciprocal multiplies, each followed by a
// subtraction), then the one-year-per-cycle and one-month-per-cycle
// calendar walks, then the finishing state. The next input is taken
// once the finishing state has loaded the result.
// The result sits in an output register; a new item is taken while it
// waits. If the receiver stalls, the next result holds in the finishing
// state until the register frees, and no further item is taken.
// Reset (aresetn low, synchronous) clears the index to 0, empties the
// output register and returns the controller to idle.
`default_nettype none

module cmos_rtc_view_from_epoch_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [7:0]  s_index_value,
    input  wire logic [31:0] s_epoch_seconds,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_read_data
);

    crtc_pkg::cmd_t    cmd;
    crtc_pkg::status_t status;

    crtc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    crtc_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_op            (s_op),
        .s_index_value   (s_index_value),
        .s_epoch_seconds (s_epoch_seconds),
        .status          (status),
        .m_read_data     (m_read_data)
    );

endmodule

`default_nettype wire

// ===== rtl/crtc_dp.sv =====
`default_nettype none

module crtc_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire crtc_pkg::cmd_t     cmd,
    input  wire logic               s_op,
    input  wire logic [7:0]         s_index_value,
    input  wire logic [31:0]        s_epoch_seconds,
    output crtc_pkg::status_t       status,
    output logic [7:0]              m_read_data
);

    logic [6:0]  index_reg;
    logic        op_reg;
    logic [31:0] q_reg;
    logic [16:0] rem_reg;
    logic [10:0] mtot_reg;
    logic [15:0] day_reg;
    logic [5:0]  sec_reg;
    logic [5:0]  min_reg;
    logic [4:0]  hour_reg;
    logic [6:0]  yy_reg;
    logic [4:0]  cent_reg;
    logic [3:0]  mon_reg;
    logic [7:0]  data_reg;

    logic [50:0] day_prod;
    logic [32:0] day_secs;
    logic [31:0] sod;
    logic [34:0] min_prod;
    logic [16:0] min_secs;
    logic [16:0] sec_diff;
    logic [28:0] hour_prod;
    logic [10:0] hour_mins;
    logic [10:0] min_diff;

    logic        leap;
    logic [8:0]  year_len;
    logic [4:0]  mon_len;
    logic [7:0]  data_next;

    // split days by reciprocal multiply, then peel off seconds and minutes
    assign day_prod  = {26'd0, q_reg[31:7]} * {25'd0, crtc_pkg::RECIP_DAY};
    assign day_secs  = {17'd0, day_reg} * {16'd0, crtc_pkg::SECS_PER_DAY};
    assign sod       = q_reg - day_secs[31:0];
    assign min_prod  = {18'd0, rem_reg} * {17'd0, crtc_pkg::RECIP_MIN};
    assign min_secs  = {6'd0, mtot_reg} * {11'd0, crtc_pkg::SECS_PER_MIN};
    assign sec_diff  = rem_reg - min_secs;
    assign hour_prod = {18'd0, mtot_reg} * {11'd0, crtc_pkg::RECIP_MIN};
    assign hour_mins = {6'd0, hour_reg} * {5'd0, crtc_pkg::MINS_PER_HOUR};
    assign min_diff  = mtot_reg - hour_mins;

    assign leap = (yy_reg[1:0] == 2'd0) && ((yy_reg != 7'd0) || (cent_reg[1:0] == 2'd0));
    assign year_len = leap ? crtc_pkg::DAYS_LEAP_YEAR : crtc_pkg::DAYS_COMMON_YEAR;
    assign mon_len  = crtc_pkg::month_days(mon_reg, leap);

    assign status = '{year_done:  (day_reg < {7'd0, year_len}),
                      month_done: (day_reg < {11'd0, mon_len})};

    always_comb begin
        data_next = 8'd0;
        if (op_reg == crtc_pkg::OP_DATA_READ) begin
            unique case (index_reg)
                crtc_pkg::REG_SECOND:   data_next = {2'd0, sec_reg};
                crtc_pkg::REG_MINUTE:   data_next = {2'd0, min_reg};
                crtc_pkg::REG_HOUR:     data_next = {3'd0, hour_reg};
                crtc_pkg::REG_DAY:      data_next = {3'd0, day_reg[4:0]} + 8'd1;
                crtc_pkg::REG_MONTH:    data_next = {4'd0, mon_reg} + 8'd1;
                crtc_pkg::REG_YEAR:     data_next = {1'b0, yy_reg};
                crtc_pkg::REG_CENTURY:  data_next = {3'd0, cent_reg};
                crtc_pkg::REG_STATUS_A: data_next = crtc_pkg::STATUS_A_VALUE;
                crtc_pkg::REG_STATUS_B: data_next = crtc_pkg::STATUS_B_VALUE;
                default:                data_next = 8'd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= 7'd0;
        end else if (cmd.accept && (s_op == crtc_pkg::OP_INDEX_WRITE)) begin
            index_reg <= s_index_value[6:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg <= s_op;
            q_reg  <= s_epoch_seconds;
        end
        if (cmd.div_day) begin
            day_reg <= day_prod[50:35];
        end
        if (cmd.load_min) begin
            rem_reg  <= sod[16:0];
            yy_reg   <= crtc_pkg::EPOCH_YY;
            cent_reg <= crtc_pkg::EPOCH_CENTURY;
        end
        if (cmd.div_min) begin
            mtot_reg <= min_prod[33:23];
        end
        if (cmd.load_hour) begin
            sec_reg <= sec_diff[5:0];
        end
        if (cmd.div_hour) begin
            hour_reg <= hour_prod[27:23];
        end
        if (cmd.load_hms) begin
            min_reg <= min_diff[5:0];
            mon_reg <= 4'd0;
        end
        if (cmd.year_step && !status.year_done) begin
            day_reg <= day_reg - {7'd0, year_len};
            if (yy_reg == crtc_pkg::LAST_YY) begin
                yy_reg   <= 7'd0;
                cent_reg <= cent_reg + 5'd1;
            end else begin
                yy_reg <= yy_reg + 7'd1;
            end
        end
        if (cmd.month_step && !status.month_done) begin
            day_reg <= day_reg - {11'd0, mon_len};
            mon_reg <= mon_reg + 4'd1;
        end
        if (cmd.out_load) begin
            data_reg <= data_next;
        end
    end

    assign m_read_data = data_reg;

endmodule

`default_nettype wire

// ===== rtl/crtc_ctrl.sv =====
`default_nettype none

module crtc_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_op,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire crtc_pkg::status_t  status,
    output crtc_pkg::cmd_t          cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DIV_DAY   = 4'd1;
    localparam logic [3:0] ST_LOAD_MIN  = 4'd2;
    localparam logic [3:0] ST_DIV_MIN   = 4'd3;
    localparam logic [3:0] ST_LOAD_HOUR = 4'd4;
    localparam logic [3:0] ST_DIV_HOUR  = 4'd5;
    localparam logic [3:0] ST_LOAD_HMS  = 4'd6;
    localparam logic [3:0] ST_YEAR      = 4'd7;
    localparam logic [3:0] ST_MONTH     = 4'd8;
    localparam logic [3:0] ST_DONE      = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (s_op == crtc_pkg::OP_DATA_READ) begin
                        state_next = ST_DIV_DAY;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV_DAY: begin
                cmd.div_day = 1'b1;
                state_next  = ST_LOAD_MIN;
            end
            ST_LOAD_MIN: begin
                cmd.load_min = 1'b1;
                state_next   = ST_DIV_MIN;
            end
            ST_DIV_MIN: begin
                cmd.div_min = 1'b1;
                state_next  = ST_LOAD_HOUR;
            end
            ST_LOAD_HOUR: begin
                cmd.load_hour = 1'b1;
                state_next    = ST_DIV_HOUR;
            end
            ST_DIV_HOUR: begin
                cmd.div_hour = 1'b1;
                state_next   = ST_LOAD_HMS;
            end
            ST_LOAD_HMS: begin
                cmd.load_hms = 1'b1;
                state_next   = ST_YEAR;
            end
            ST_YEAR: begin
                cmd.year_step = 1'b1;
                if (status.year_done) begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                cmd.month_step = 1'b1;
                if (status.month_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_write_goes_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_valid && s_op == crtc_pkg::OP_INDEX_WRITE)
        |=> (state_reg == ST_DONE))
        else $error("index write did not go straight to result");

    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten while pending");

    a_month_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MONTH && !status.month_done) |=> (state_reg == ST_MONTH))
        else $error("month walk left early");

    a_read_starts_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_valid && s_op == crtc_pkg::OP_DATA_READ)
        |=> (state_reg == ST_DIV_DAY))
        else $error("data read did not start the day split");
`endif

endmodule

`default_nettype wire

// ===== test/cmos_rtc_view_from_epoch_top_test.sv =====
`timescale 1ns / 1ps

module cmos_rtc_view_from_epoch_top_test;

    typedef struct packed {
        logic        op;
        logic [7:0]  value;
        logic [31:0] secs;
        logic [1:0]  phase;
        logic        drain;
    } rtc_access_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic        s_op = crtc_pkg::OP_INDEX_WRITE;
    logic [7:0]  s_index_value = 8'h00;
    logic [31:0] s_epoch_seconds = 32'h0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire  [7:0]  m_read_data;

    rtc_access_t pending_access[$];
    logic [7:0]  expected_bytes[$];
    rtc_access_t next_access;
    logic [6:0]  model_index = '0;
    logic [7:0]  byte_wanted;
    logic [1:0]  cur_phase = 2'd0;
    int          mismatch_count = 0;

    cmos_rtc_view_from_epoch_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_index_value   (s_index_value),
        .s_epoch_seconds (s_epoch_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
        case (m)
            1:           return leap ? 29 : 28;
            3, 5, 8, 10: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic int unsigned send_idle_pct(input logic [1:0] ph);
        return (ph == 2'd0) ? 23 : (ph == 2'd1) ? 60 : 0;
    endfunction

    function automatic int unsigned recv_stall_pct(input logic [1:0] ph);
        return (ph == 2'd0) ? 60 : (ph == 2'd1) ? 23 : 0;
    endfunction

    // Split epoch seconds into the civil field chosen by the register index.
    function automatic logic [7:0] civil_field(input logic [31:0] secs, input logic [6:0] idx);
        int unsigned t, sec, mins, hrs, yr, mon, span;
        bit          leap;
        t    = secs;
        sec  = t % 60;
        t    = t / 60;
        mins = t % 60;
        t    = t / 60;
        hrs  = t % 24;
        t    = t / 24;
        yr   = 1970;
        span = 365;
        while (t >= span) begin
            t    = t - span;
            yr   = yr + 1;
            span = leap_year(yr) ? 366 : 365;
        end
        leap = leap_year(yr);
        mon  = 0;
        span = 31;
        while (t >= span) begin
            t    = t - span;
            mon  = mon + 1;
            span = days_in_month(mon, leap);
        end
        case (idx)
            crtc_pkg::REG_SECOND:   return 8'(sec);
            crtc_pkg::REG_MINUTE:   return 8'(mins);
            crtc_pkg::REG_HOUR:     return 8'(hrs);
            crtc_pkg::REG_DAY:      return 8'(t + 1);
            crtc_pkg::REG_MONTH:    return 8'(mon + 1);
            crtc_pkg::REG_YEAR:     return 8'(yr % 100);
            crtc_pkg::REG_CENTURY:  return 8'(yr / 100);
            crtc_pkg::REG_STATUS_A: return crtc_pkg::STATUS_A_VALUE;
            crtc_pkg::REG_STATUS_B: return crtc_pkg::STATUS_B_VALUE;
            default:                return 8'h00;
        endcase
    endfunction

    task automatic queue_access(input logic op, input logic [7:0] value, input logic [31:0] secs,
                                input logic [1:0] ph, input logic hold);
        rtc_access_t a;
        a.op    = op;
        a.value = value;
        a.secs  = secs;
        a.phase = ph;
        a.drain = hold;
        pending_access.push_back(a);
    endtask

    // Driver: predict on each input transfer, then present the next access.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            model_index = '0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_op == crtc_pkg::OP_INDEX_WRITE) begin
                    model_index = s_index_value[6:0];
                    expected_bytes.push_back(8'h00);
                end else begin
                    expected_bytes.push_back(civil_field(s_epoch_seconds, model_index));
                end
            end
            if (!s_valid || s_ready) begin
                if (pending_access.size() == 0
                        || (pending_access[0].drain && expected_bytes.size() != 0)
                        || $urandom_range(99) < send_idle_pct(pending_access[0].phase)) begin
                    s_valid <= 1'b0;
                end else begin
                    next_access = pending_access.pop_front();
                    cur_phase = next_access.phase;
                    s_valid         <= 1'b1;
                    s_op            <= next_access.op;
                    s_index_value   <= next_access.value;
                    s_epoch_seconds <= next_access.secs;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transfer: read_data=%02h", m_read_data);
                end else begin
                    byte_wanted = expected_bytes.pop_front();
                    if (m_read_data !== byte_wanted) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("read_data mismatch: expected %02h, got %02h",
                                     byte_wanted, m_read_data);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct(cur_phase));
        end
    end

    initial begin
        int          i;
        logic [1:0]  ph;
        logic [6:0]  reg_pick;
        logic [31:0] secs;
        logic [7:0]  value;

        // extremes, leap day, century boundary, every register, dropped top bit
        queue_access(crtc_pkg::OP_DATA_READ, 8'hFF, 32'hFFFF_FFFF, 2'd0, 1'b0);
        queue_access(crtc_pkg::OP_INDEX_WRITE, {1'b1, crtc_pkg::REG_MINUTE}, 32'hFFFF_FFFF,
                     2'd0, 1'b0);
        queue_access(crtc_pkg::OP_DATA_READ, 8'h00, 32'h0, 2'd0, 1'b0);
        queue_access(crtc_pkg::OP_INDEX_WRITE, {1'b0, crtc_pkg::REG_HOUR}, 32'h0, 2'd0, 1'b0);
        queue_access(crtc_pkg::OP_DATA_READ, 8'hFF, 32'd86399, 2'd0, 1'b0);
        queue_access(crtc_pkg::OP_INDEX_WRITE, {1'b0, crtc_pkg::REG_DAY}, $urandom, 2'd0, 1'b0);
        queue_access(crtc_pkg::OP_DATA_READ, 8'h00, 32'd951782400, 2'd0, 1'b0);
        queue_access(crtc_pkg::OP_INDEX_WRITE, {1'b1, crtc_pkg::REG_MONTH}, $urandom,
                     2'd0, 1'b0);
        queue_access(crtc_pkg::OP_DATA_READ, 8'h55, 32'hFFFF_FFFF, 2'd0, 1'b0);
        queue_access(crtc_pkg::OP_INDEX_WRITE, {1'b0, crtc_pkg::REG_YEAR}, $urandom,
                     2'd0, 1'b0);
        queue_access(crtc_pkg::OP_DATA_READ, 8'hAA, 32'd946684799, 2'd0, 1'b0);
        queue_access(crtc_pkg::OP_INDEX_WRITE, {1'b1, crtc_pkg::REG_CENTURY}, $urandom,
                     2'd0, 1'b0);
        queue_access(crtc_pkg::OP_DATA_READ, 8'h00, 32'd4102444800, 2'd0, 1'b0);
        queue_access(crtc_pkg::OP_DATA_READ, 8'h00, 32'd4102444799, 2'd0, 1'b0);
        queue_access(crtc_pkg::OP_INDEX_WRITE, {1'b0, crtc_pkg::REG_STATUS_A}, $urandom,
                     2'd0, 1'b0);
        queue_access(crtc_pkg::OP_DATA_READ, 8'hFF, $urandom, 2'd0, 1'b0);
        queue_access(crtc_pkg::OP_INDEX_WRITE, {1'b0, crtc_pkg::REG_STATUS_B}, $urandom,
                     2'd0, 1'b0);
        queue_access(crtc_pkg::OP_DATA_READ, 8'h00, 32'h0, 2'd0, 1'b0);
        queue_access(crtc_pkg::OP_INDEX_WRITE, 8'hFF, 32'hFFFF_FFFF, 2'd0, 1'b0);
        queue_access(crtc_pkg::OP_DATA_READ, 8'hFF, 32'hFFFF_FFFF, 2'd0, 1'b0);
        queue_access(crtc_pkg::OP_INDEX_WRITE, 8'h80, 32'h0, 2'd0, 1'b0);
        queue_access(crtc_pkg::OP_DATA_READ, 8'h00, 32'h7FFF_FFFF, 2'd0, 1'b0);

        for (i = 0; i < 700; i++) begin
            ph = (i < 230) ? 2'd0 : (i < 460) ? 2'd1 : 2'd2;
            if ($urandom_range(99) < 30) begin
                case ($urandom_range(8))
                    0:       reg_pick = crtc_pkg::REG_SECOND;
                    1:       reg_pick = crtc_pkg::REG_MINUTE;
                    2:       reg_pick = crtc_pkg::REG_HOUR;
                    3:       reg_pick = crtc_pkg::REG_DAY;
                    4:       reg_pick = crtc_pkg::REG_MONTH;
                    5:       reg_pick = crtc_pkg::REG_YEAR;
                    6:       reg_pick = crtc_pkg::REG_CENTURY;
                    7:       reg_pick = crtc_pkg::REG_STATUS_A;
                    default: reg_pick = crtc_pkg::REG_STATUS_B;
                endcase
                value = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                 : {1'($urandom_range(1)), reg_pick};
                queue_access(crtc_pkg::OP_INDEX_WRITE, value, $urandom, ph,
                             (i == 230 || i == 460 || $urandom_range(99) == 0));
            end else begin
                case ($urandom_range(3))
                    0: secs = $urandom;
                    1: secs = $urandom_range(49709) * 32'd86400
                              + ($urandom_range(1) ? 32'd86399 : 32'd0);
                    2: secs = $urandom_range(32'd199_999_999);
                    default: secs = 32'hFFFF_FFFF - $urandom_range(32'd50_000_000);
                endcase
                queue_access(crtc_pkg::OP_DATA_READ, 8'($urandom_range(255)), secs, ph,
                             (i == 230 || i == 460 || $urandom_range(99) == 0));
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        @(posedge aclk);
        while (pending_access.size() != 0 || s_valid || expected_bytes.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);

        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("cmos_rtc_view_from_epoch_top verification clean");
        end else begin
            $display("cmos_rtc_view_from_epoch_top verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("cmos_rtc_view_from_epoch_top verification failed");
        $finish;
    end

endmodule
